@@ design/u8cs_pkg.sv @@
// shared types, register codes and the code point fold tables
// used by every module of the utf-8 to caps ascii sanitizer
package u8cs_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       is_end;
    logic [7:0] char_count;
  } out_item_t;

  // one queued work unit: up to two folded characters, then maybe an end marker
  typedef struct packed {
    logic [6:0] c0;
    logic [6:0] c1;
    logic       is_end;
  } work_t;

  localparam int unsigned CpW = 21;

  // configuration register indexes
  localparam logic CFG_MAX_WORD_RUN = 1'b0;
  localparam logic CFG_MAX_CHARS    = 1'b1;

  localparam logic [5:0] MAX_WORD_RUN_RST = 6'd18;
  localparam logic [7:0] MAX_CHARS_RST    = 8'd199;

  localparam logic [6:0] CHAR_NONE  = 7'h00;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  // u+00c0 .. u+00ff, first character in the top byte
  localparam logic [64*8-1:0] LATIN1_STR =
    {"AAAAAAACEEEEIIII", "DNOOOOOxOUUUUYPS", "AAAAAAACEEEEIIII", "DNOOOOOxOUUUUYPY"};

  // u+0100 .. u+017f
  localparam logic [128*8-1:0] LATIN_EXT_A_STR =
    {"AAAAAACCCCCCCCDD", "DDEEEEEEEEEEGGGG", "GGGGHHHHIIIIIIII", "IIIIJJKKKLLLLLLL",
     "LLLNNNNNNNNNOOOO", "OOOORRRRRRSSSSSS", "SSTTTTTTUUUUUUUU", "UUUUWWYYYZZZZZZS"};

  // fold a code point to upper-case printable ascii, zero when dropped
  function automatic logic [6:0] fold_cp(logic [CpW-1:0] cp);
    logic [7:0] ch;
    ch = 8'h00;
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      ch = {1'b0, cp[6:0]};
    end else if (cp >= 21'hC0 && cp <= 21'hFF) begin
      ch = LATIN1_STR[{~cp[5:0], 3'b000} +: 8];
    end else if (cp >= 21'h100 && cp <= 21'h17F) begin
      ch = LATIN_EXT_A_STR[{~cp[6:0], 3'b000} +: 8];
    end else begin
      case (cp)
        21'h2018, 21'h2019: ch = 8'h27;
        21'h201C, 21'h201D: ch = 8'h22;
        21'h2013, 21'h2014: ch = 8'h2D;
        21'h2026:           ch = 8'h2E;
        21'h00A0:           ch = 8'h20;
        default:            ch = 8'h00;
      endcase
    end
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      ch = ch - 8'h20;
    end
    return ch[6:0];
  endfunction

endpackage

@@ design/u8cs_front.sv @@
// front end: utf-8 sequence decode and code point fold
// depends on u8cs_pkg
module u8cs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  u8cs_pkg::in_item_t in_data_i,
  output logic               push_o,
  output u8cs_pkg::work_t    work_o
);
  import u8cs_pkg::*;

  logic [CpW-1:0] part_q, part_d;
  logic [1:0]     cont_q, cont_d;
  logic [CpW-1:0] shifted;
  logic [7:0]     b;
  logic           accept;
  work_t          work;

  assign accept = in_valid_i && in_ready_i;
  assign b      = in_data_i.text_byte;
  assign shifted = {part_q[CpW-7:0], b[5:0]};

  always_comb begin
    work   = '0;
    part_d = part_q;
    cont_d = cont_q;
    if (in_data_i.end_of_message) begin
      if (cont_q != 2'd0) begin
        work.c0 = fold_cp(part_q);
      end
      work.is_end = 1'b1;
      part_d = '0;
      cont_d = 2'd0;
    end else if (cont_q != 2'd0 && b[7:6] == 2'b10) begin
      cont_d = cont_q - 2'd1;
      if (cont_q == 2'd1) begin
        work.c0 = fold_cp(shifted);
        part_d  = '0;
      end else begin
        part_d = shifted;
      end
    end else begin
      // cut-short sequence folds what it has gathered
      if (cont_q != 2'd0) begin
        work.c0 = fold_cp(part_q);
        part_d  = '0;
        cont_d  = 2'd0;
      end
      if (!b[7]) begin
        work.c1 = fold_cp({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        part_d = {16'd0, b[4:0]};
        cont_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_d = {17'd0, b[3:0]};
        cont_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part_d = {18'd0, b[2:0]};
        cont_d = 2'd3;
      end
    end
  end

  assign push_o = accept && (work.c0 != CHAR_NONE || work.c1 != CHAR_NONE || work.is_end);
  assign work_o = work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      cont_q <= 2'd0;
    end else if (accept) begin
      part_q <= part_d;
      cont_q <= cont_d;
    end
  end

endmodule

@@ design/u8cs_queue.sv @@
// small fifo of work units between front and back end
// depends on u8cs_pkg
module u8cs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8cs_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output u8cs_pkg::work_t head_o
);
  import u8cs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/u8cs_back.sv @@
// back end: word-break insertion, character cap, end marker, output register
// depends on u8cs_pkg
module u8cs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          max_word_run_i,
  input  logic [7:0]          max_chars_i,
  input  logic                head_valid_i,
  input  u8cs_pkg::work_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cs_pkg::out_item_t out_data_o
);
  import u8cs_pkg::*;

  logic [2:0] done_q, done_d;
  logic [2:0] present, remaining, slot_bit, new_done;
  logic       sp_done_q, sp_done_d;
  logic [5:0] word_run_q, word_run_d;
  logic [7:0] count_q, count_d, count_inc;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;
  logic       can_emit, step, emit, finish;
  logic [6:0] ch;
  out_item_t  res;

  assign can_emit  = !out_valid_q || out_ready_i;
  assign step      = head_valid_i && can_emit;
  assign present   = {head_i.is_end, head_i.c1 != CHAR_NONE, head_i.c0 != CHAR_NONE};
  assign remaining = present & ~done_q;
  assign count_inc = count_q + 8'd1;

  always_comb begin
    // slots run in order: sequence fold, then new byte, then end marker
    if (remaining[0]) begin
      slot_bit = 3'b001;
    end else if (remaining[1]) begin
      slot_bit = 3'b010;
    end else begin
      slot_bit = 3'b100;
    end
    ch = slot_bit[0] ? head_i.c0 : head_i.c1;

    emit       = 1'b0;
    finish     = 1'b0;
    res        = '0;
    word_run_d = word_run_q;
    count_d    = count_q;
    sp_done_d  = sp_done_q;

    if (slot_bit[2]) begin
      emit           = 1'b1;
      finish         = 1'b1;
      res.is_end     = 1'b1;
      res.char_count = count_q;
      word_run_d     = '0;
      count_d        = '0;
      sp_done_d      = 1'b0;
    end else if (count_q >= max_chars_i) begin
      finish    = 1'b1;
      sp_done_d = 1'b0;
    end else if (ch == CHAR_SPACE) begin
      emit         = 1'b1;
      finish       = 1'b1;
      res.out_char = CHAR_SPACE;
      word_run_d   = '0;
      count_d      = count_inc;
      sp_done_d    = 1'b0;
    end else if (!sp_done_q && word_run_q >= max_word_run_i) begin
      // forced space first; char itself goes next beat unless the cap is hit
      emit         = 1'b1;
      res.out_char = CHAR_SPACE;
      word_run_d   = '0;
      count_d      = count_inc;
      if (count_inc >= max_chars_i) begin
        finish    = 1'b1;
        sp_done_d = 1'b0;
      end else begin
        sp_done_d = 1'b1;
      end
    end else begin
      emit         = 1'b1;
      finish       = 1'b1;
      res.out_char = ch;
      word_run_d   = word_run_q + 6'd1;
      count_d      = count_inc;
      sp_done_d    = 1'b0;
    end

    new_done = done_q | (finish ? slot_bit : 3'b000);
    pop_o    = step && finish && ((present & ~new_done) == 3'b000);
    done_d   = pop_o ? 3'b000 : new_done;

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (can_emit) begin
      out_valid_d = step && emit;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      sp_done_q   <= 1'b0;
      word_run_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        done_q     <= done_d;
        sp_done_q  <= sp_done_d;
        word_run_q <= word_run_d;
        count_q    <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ design/utf8_to_caps_ascii_sanitizer.sv @@
// top level of the utf-8 to caps ascii sanitizer: config registers and wiring
// depends on u8cs_pkg, u8cs_front, u8cs_queue, u8cs_back
//
//  channel | direction | handshake                    | beat
//  --------+-----------+------------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o      | text_byte, end_of_message
//  out     | output    | out_valid_o / out_ready_i    | out_char, is_end, char_count
//  cfg     | input     | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// one input beat per cycle while the queue has room; each queued character or end marker,
// even one dropped at the cap, and each forced space takes a back-end step of its own, and
// the back end does not step while the output is stalled; a byte that folds to nothing
// is never queued
// an input beat reaches the output through the queue, then the output register
// in_ready_o drops only when the QueueDepth-entry queue is full
// reset sets max_word_run to 18 and max_chars to 199 and clears all message state
module utf8_to_caps_ascii_sanitizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u8cs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u8cs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import u8cs_pkg::*;

  logic [5:0] max_word_run_q;
  logic [7:0] max_chars_q;

  // queue link
  logic  push, full, pop, head_valid;
  work_t push_work, head_work;

  // config registers, to be written only while the block is idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_word_run_q <= MAX_WORD_RUN_RST;
      max_chars_q    <= MAX_CHARS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_WORD_RUN: max_word_run_q <= cfg_data_i[5:0];
        CFG_MAX_CHARS:    max_chars_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accept while the queue has a free slot
  assign in_ready_o = !full;

  // decode and fold each byte
  u8cs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .work_o     (push_work)
  );

  // decouples decode from output backpressure
  u8cs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_work),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_work)
  );

  // word breaks, cap, end marker and the output register
  u8cs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_word_run_i (max_word_run_q),
    .max_chars_i    (max_chars_q),
    .head_valid_i   (head_valid),
    .head_i         (head_work),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

@@ design/u8cs_checker.sv @@
// port-level checks on the sanitizer output channel, bound to the top level
// depends on u8cs_pkg and utf8_to_caps_ascii_sanitizer
module u8cs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u8cs_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_end_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_end |-> out_data_o.out_char == 7'h00)
    else $error("end marker carries a character");

  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_end |->
      out_data_o.out_char >= 7'h20 && out_data_o.out_char <= 7'h7E &&
      out_data_o.char_count == 8'h00)
    else $error("character beat not printable or carries a count");

  a_char_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_end |->
      !(out_data_o.out_char >= 7'h61 && out_data_o.out_char <= 7'h7A))
    else $error("lower-case letter on output");

endmodule

bind utf8_to_caps_ascii_sanitizer u8cs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
